// File: sv/kvdp_pkg.sv
// shared types and constants of the key=value decimal parser
package kvdp_pkg;

   localparam int OFFSET_W = 16;
   localparam int VALUE_W  = 64;

   localparam logic [7:0] CHAR_NUL    = 8'd0;
   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_CR     = 8'd13;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_PLUS   = 8'd43;
   localparam logic [7:0] CHAR_MINUS  = 8'd45;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_NINE   = 8'd57;
   localparam logic [7:0] CHAR_EQUALS = 8'd61;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_JUNK  = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]                code;
      logic [OFFSET_W-1:0]       offset;
      logic signed [VALUE_W-1:0] value;
   } status_type;

endpackage

// File: sv/kvdp_ifs.sv
// request and response channel interfaces of the key=value decimal parser
interface kvdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_end;

   modport source (output valid, output char_code, output line_end, input ready);
   modport sink (input valid, input char_code, input line_end, output ready);
endinterface

interface kvdp_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_status;
   logic [7:0]  key_char;
   logic [1:0]  status_code;
   logic [15:0] error_offset;
   logic signed [63:0] parsed_value;

   modport source (output valid, output is_status, output key_char, output status_code,
                   output error_offset, output parsed_value, input ready);
   modport sink (input valid, input is_status, input key_char, input status_code,
                 input error_offset, input parsed_value, output ready);
endinterface

// File: sv/kvdp_scan.sv
// per-byte line scanner: key capture, value accumulation and final status
module kvdp_scan #(
   parameter int KEY_CAPACITY = 32,
   parameter int OFFSET_MAX   = 65535,
   parameter int LEN_W        = 6,
   parameter int ADDR_W       = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic                   line_done,
   input  logic [7:0]             char_code,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data,
   output kvdp_pkg::status_type   status,
   output logic [LEN_W-1:0]       key_count
);

   localparam logic [2:0] PH_KEY       = 3'd0;
   localparam logic [2:0] PH_KEY_EMPTY = 3'd1;
   localparam logic [2:0] PH_KEY_LONG  = 3'd2;
   localparam logic [2:0] PH_SPACE     = 3'd3;
   localparam logic [2:0] PH_SIGN      = 3'd4;
   localparam logic [2:0] PH_DIGITS    = 3'd5;
   localparam logic [2:0] PH_JUNK      = 3'd6;
   localparam logic [2:0] PH_NODIGIT   = 3'd7;

   localparam logic [LEN_W-1:0] KEY_FULL  = LEN_W'(KEY_CAPACITY);
   localparam logic [LEN_W-1:0] STORE_TOP = LEN_W'(KEY_CAPACITY - 1);
   localparam logic [15:0]      OFF_SAT   = 16'(OFFSET_MAX);

   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] key_length_ff, key_length_in;
   logic [15:0]      line_position_ff, line_position_in;
   logic [63:0]      magnitude_ff, magnitude_in;
   logic             overflow_ff, overflow_in;
   logic             negative_ff, negative_in;

   logic        is_space;
   logic        is_digit;
   logic        is_sign;
   logic [3:0]  digit_value;
   logic [67:0] scaled;
   logic [67:0] limit;
   logic        too_big;
   logic [15:0] value_offset;

   assign is_space = (char_code == kvdp_pkg::CHAR_SPACE) ||
                     ((char_code >= kvdp_pkg::CHAR_TAB) && (char_code <= kvdp_pkg::CHAR_CR));
   assign is_digit = (char_code >= kvdp_pkg::CHAR_ZERO) && (char_code <= kvdp_pkg::CHAR_NINE);
   assign is_sign  = (char_code == kvdp_pkg::CHAR_PLUS) || (char_code == kvdp_pkg::CHAR_MINUS);
   assign digit_value = 4'(char_code - kvdp_pkg::CHAR_ZERO);

   // magnitude*10 + digit against 2^63-1, or 2^63 once a minus sign is seen
   assign scaled  = {1'b0, magnitude_ff, 3'b000} + {3'b000, magnitude_ff, 1'b0} +
                    {64'd0, digit_value};
   assign limit   = {5'd0, {63{1'b1}}} + {67'd0, negative_ff};
   assign too_big = scaled > limit;

   assign wr_en   = byte_valid && (phase_ff == PH_KEY) &&
                    (char_code != kvdp_pkg::CHAR_EQUALS) && (key_length_ff < STORE_TOP);
   assign wr_addr = key_length_ff[ADDR_W-1:0];
   assign wr_data = char_code;

   always_comb begin
      phase_in         = phase_ff;
      key_length_in    = key_length_ff;
      line_position_in = line_position_ff;
      magnitude_in     = magnitude_ff;
      overflow_in      = overflow_ff;
      negative_in      = negative_ff;
      if (line_done) begin
         phase_in         = PH_KEY;
         key_length_in    = '0;
         line_position_in = '0;
         magnitude_in     = '0;
         overflow_in      = 1'b0;
         negative_in      = 1'b0;
      end else if (byte_valid) begin
         case (phase_ff)
            PH_KEY: begin
               if (char_code == kvdp_pkg::CHAR_EQUALS) begin
                  if (key_length_ff == '0) begin
                     phase_in = PH_KEY_EMPTY;
                  end else if (key_length_ff >= KEY_FULL) begin
                     phase_in = PH_KEY_LONG;
                  end else begin
                     phase_in = PH_SPACE;
                  end
               end else if (key_length_ff < KEY_FULL) begin
                  key_length_in = key_length_ff + LEN_W'(1);
               end
            end
            PH_SPACE: begin
               if (is_space) begin
                  phase_in = PH_SPACE;
               end else if (is_sign) begin
                  negative_in = (char_code == kvdp_pkg::CHAR_MINUS);
                  phase_in    = PH_SIGN;
               end else if (is_digit) begin
                  if (too_big) overflow_in = 1'b1;
                  else magnitude_in = scaled[63:0];
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_NODIGIT;
               end
            end
            PH_SIGN: begin
               if (is_digit) begin
                  if (too_big) overflow_in = 1'b1;
                  else magnitude_in = scaled[63:0];
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_NODIGIT;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  if (!overflow_ff) begin
                     if (too_big) overflow_in = 1'b1;
                     else magnitude_in = scaled[63:0];
                  end
               end else begin
                  phase_in = PH_JUNK;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (line_position_ff < OFF_SAT) line_position_in = line_position_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_KEY;
         key_length_ff    <= '0;
         line_position_ff <= '0;
         magnitude_ff     <= '0;
         overflow_ff      <= 1'b0;
         negative_ff      <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         key_length_ff    <= key_length_in;
         line_position_ff <= line_position_in;
         magnitude_ff     <= magnitude_in;
         overflow_ff      <= overflow_in;
         negative_ff      <= negative_in;
      end
   end

   // offset of the value field, just past the '='
   always_comb begin
      value_offset = 16'(key_length_ff) + 16'd1;
      if (value_offset > OFF_SAT) value_offset = OFF_SAT;
   end

   always_comb begin
      status.code   = kvdp_pkg::STATUS_OK;
      status.offset = '0;
      status.value  = '0;
      case (phase_ff)
         PH_KEY: begin
            status.code   = kvdp_pkg::STATUS_JUNK;
            status.offset = line_position_ff;
         end
         PH_KEY_EMPTY: begin
            status.code = kvdp_pkg::STATUS_EMPTY;
         end
         PH_KEY_LONG: begin
            status.code = kvdp_pkg::STATUS_RANGE;
         end
         PH_SPACE, PH_SIGN, PH_NODIGIT: begin
            status.code   = kvdp_pkg::STATUS_EMPTY;
            status.offset = value_offset;
         end
         PH_JUNK: begin
            status.code   = kvdp_pkg::STATUS_JUNK;
            status.offset = value_offset;
         end
         PH_DIGITS: begin
            if (overflow_ff) begin
               status.code   = kvdp_pkg::STATUS_RANGE;
               status.offset = value_offset;
            end else begin
               status.value = negative_ff ? -magnitude_ff : magnitude_ff;
            end
         end
         default: begin
            status.code = kvdp_pkg::STATUS_JUNK;
         end
      endcase
   end

   assign key_count = (status.code == kvdp_pkg::STATUS_OK) ? key_length_ff : '0;

endmodule

// File: sv/kvdp_key_store.sv
// key byte store: one write port, one registered read port
module kvdp_key_store #(
   parameter int DEPTH  = 31,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/kvdp_emit.sv
// end-of-line sequencer: drains key bytes then the status into the response register
module kvdp_emit #(
   parameter int LEN_W  = 6,
   parameter int ADDR_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 line_done,
   input  kvdp_pkg::status_type status,
   input  logic [LEN_W-1:0]     key_count,
   output logic [ADDR_W-1:0]    rd_addr,
   input  logic [7:0]           rd_data,
   output logic                 busy,
   kvdp_rsp_if.source           rsp
);

   logic                 busy_ff, busy_in;
   logic [LEN_W-1:0]     emit_index_ff, emit_index_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   kvdp_pkg::status_type status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_is_status_ff, rsp_is_status_in;
   logic [7:0]         rsp_key_char_ff, rsp_key_char_in;
   logic [1:0]         rsp_code_ff, rsp_code_in;
   logic [15:0]        rsp_offset_ff, rsp_offset_in;
   logic signed [63:0] rsp_value_ff, rsp_value_in;

   logic slot_free;
   logic load;
   logic more_keys;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign load      = busy_ff && slot_free;
   assign more_keys = emit_index_ff < count_ff;

   always_comb begin
      busy_in          = busy_ff;
      emit_index_in    = emit_index_ff;
      count_in         = count_ff;
      status_in        = status_ff;
      rsp_is_status_in = rsp_is_status_ff;
      rsp_key_char_in  = rsp_key_char_ff;
      rsp_code_in      = rsp_code_ff;
      rsp_offset_in    = rsp_offset_ff;
      rsp_value_in     = rsp_value_ff;
      if (line_done) begin
         busy_in       = 1'b1;
         emit_index_in = '0;
         count_in      = key_count;
         status_in     = status;
      end else if (load) begin
         if (more_keys) begin
            rsp_is_status_in = 1'b0;
            rsp_key_char_in  = rd_data;
            rsp_code_in      = kvdp_pkg::STATUS_OK;
            rsp_offset_in    = '0;
            rsp_value_in     = '0;
            emit_index_in    = emit_index_ff + LEN_W'(1);
         end else begin
            rsp_is_status_in = 1'b1;
            rsp_key_char_in  = '0;
            rsp_code_in      = status_ff.code;
            rsp_offset_in    = status_ff.offset;
            rsp_value_in     = status_ff.value;
            emit_index_in    = '0;
            busy_in          = 1'b0;
         end
      end
      if (load) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         emit_index_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         emit_index_ff <= emit_index_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff        <= status_in;
      rsp_is_status_ff <= rsp_is_status_in;
      rsp_key_char_ff  <= rsp_key_char_in;
      rsp_code_ff      <= rsp_code_in;
      rsp_offset_ff    <= rsp_offset_in;
      rsp_value_ff     <= rsp_value_in;
   end

   // read one entry ahead so the store output lines up with emit_index_ff
   assign rd_addr = emit_index_in[ADDR_W-1:0];
   assign busy    = busy_ff;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.is_status    = rsp_is_status_ff;
   assign rsp.key_char     = rsp_key_char_ff;
   assign rsp.status_code  = rsp_code_ff;
   assign rsp.error_offset = rsp_offset_ff;
   assign rsp.parsed_value = rsp_value_ff;

endmodule

// File: sv/key_value_decimal_parser.sv
// top level of the key=value decimal parser
//
//   channel  direction  carries
//   req_ch   in         char_code, line_end (one line byte or end of line)
//   rsp_ch   out        is_status, key_char, status_code, error_offset, parsed_value
//
// one line byte per cycle while no end-of-line drain is blocking req_ch
// an end-of-line request blocks req_ch, and rsp stalls extend the block, while the
// key bytes leave the key store through its registered read port and the status follows
// first response is registered once busy is set and the response register is free
// rsp stalls hold the response register; line bytes keep flowing while it is full and no line drains
// synchronous reset clears the scanner and the drain sequencer, no clearing pass
module key_value_decimal_parser #(
   parameter int KEY_CAPACITY = 32,
   parameter int OFFSET_MAX   = 65535
) (
   input  logic       clock,
   input  logic       reset,
   kvdp_req_if.sink   req_ch,
   kvdp_rsp_if.source rsp_ch
);

   localparam int LEN_W       = $clog2(KEY_CAPACITY + 1);
   localparam int STORE_DEPTH = KEY_CAPACITY - 1;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic                 req_fire;
   logic                 is_end;
   logic                 line_done;
   logic                 byte_valid;
   logic                 busy;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [7:0]           wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [7:0]           rd_data;
   kvdp_pkg::status_type status;
   logic [LEN_W-1:0]     key_count;

   assign req_ch.ready = !busy;
   assign req_fire     = req_ch.valid && req_ch.ready;
   // a nul byte ends the line like the marker does
   assign is_end       = req_ch.line_end || (req_ch.char_code == kvdp_pkg::CHAR_NUL);
   assign line_done    = req_fire && is_end;
   assign byte_valid   = req_fire && !is_end;

   kvdp_scan #(
      .KEY_CAPACITY (KEY_CAPACITY),
      .OFFSET_MAX   (OFFSET_MAX),
      .LEN_W        (LEN_W),
      .ADDR_W       (ADDR_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .line_done  (line_done),
      .char_code  (req_ch.char_code),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .status     (status),
      .key_count  (key_count)
   );

   kvdp_key_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kvdp_emit #(
      .LEN_W  (LEN_W),
      .ADDR_W (ADDR_W)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .line_done (line_done),
      .status    (status),
      .key_count (key_count),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .busy      (busy),
      .rsp       (rsp_ch)
   );

endmodule

// File: sv/kvdp_checker.sv
// port-level checks of the key=value decimal parser, bound to the top level
module kvdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_code,
   input logic        req_line_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_status,
   input logic [7:0]  rsp_key_char,
   input logic [1:0]  rsp_status_code,
   input logic [15:0] rsp_error_offset,
   input logic [63:0] rsp_parsed_value
);

   logic end_taken;

   assign end_taken = req_valid && req_ready &&
                      (req_line_end || (req_char_code == kvdp_pkg::CHAR_NUL));

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_is_status) &&
         $stable(rsp_key_char) && $stable(rsp_status_code) &&
         $stable(rsp_error_offset) && $stable(rsp_parsed_value)))
      else $error("stalled response changed");

   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      end_taken |=> !req_ready)
      else $error("request taken while the line drains");

   a_key_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_status) |-> ((rsp_status_code == kvdp_pkg::STATUS_OK) &&
         (rsp_error_offset == 16'd0) && (rsp_parsed_value == 64'd0)))
      else $error("key byte response carries status fields");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_status && (rsp_status_code != kvdp_pkg::STATUS_OK)) |->
         ((rsp_parsed_value == 64'd0) && (rsp_key_char == 8'd0)))
      else $error("failed status carries a value");

endmodule

bind key_value_decimal_parser kvdp_checker u_kvdp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_char_code    (req_ch.char_code),
   .req_line_end     (req_ch.line_end),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_is_status    (rsp_ch.is_status),
   .rsp_key_char     (rsp_ch.key_char),
   .rsp_status_code  (rsp_ch.status_code),
   .rsp_error_offset (rsp_ch.error_offset),
   .rsp_parsed_value (rsp_ch.parsed_value)
);

// File: tb/sv/key_value_decimal_parser_test.sv
// self-checking testbench of the key=value decimal parser
module key_value_decimal_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_CAPACITY = 32;
   localparam int OFFSET_MAX   = 65535;
   localparam int RANDOM_ITEMS = 40;
   localparam int DRAIN_LIMIT  = 20000;

   typedef enum logic [2:0] {
      SCAN_KEY, SCAN_KEY_EMPTY, SCAN_KEY_LONG, SCAN_SPACE,
      SCAN_SIGN, SCAN_DIGITS, SCAN_JUNK, SCAN_NODIGIT
   } scan_phase_type;

   typedef struct {
      logic                 is_status;
      logic [7:0]           key_char;
      kvdp_pkg::status_type status;
   } parse_result_type;

   logic clock;
   logic reset;

   kvdp_req_if req_if ();
   kvdp_rsp_if rsp_if ();

   key_value_decimal_parser #(
      .KEY_CAPACITY (KEY_CAPACITY),
      .OFFSET_MAX   (OFFSET_MAX)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // line scanner mirror
   scan_phase_type scan_phase;
   logic [7:0]     key_bytes [KEY_CAPACITY-1];
   int             key_count;
   int             line_pos;
   logic [63:0]    magnitude;
   bit             overflowed;
   bit             negative;

   parse_result_type line_results [$];

   int error_count;
   int items_sent;
   int burst_left;
   int hold_cycles;
   bit gaps_on;
   bit rsp_stall_on;
   bit sender_active;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_scan();
      scan_phase = SCAN_KEY;
      key_count  = 0;
      line_pos   = 0;
      magnitude  = '0;
      overflowed = 0;
      negative   = 0;
   endfunction

   function automatic bit is_space_char(logic [7:0] c);
      return c == kvdp_pkg::CHAR_SPACE ||
             (c >= kvdp_pkg::CHAR_TAB && c <= kvdp_pkg::CHAR_CR);
   endfunction

   function automatic bit is_digit_char(logic [7:0] c);
      return c >= kvdp_pkg::CHAR_ZERO && c <= kvdp_pkg::CHAR_NINE;
   endfunction

   function automatic void accumulate_digit(logic [7:0] c);
      logic [63:0] limit;
      logic [63:0] d;
      limit = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      d = 64'(c - kvdp_pkg::CHAR_ZERO);
      if (overflowed)
         return;
      if (magnitude > (limit - d) / 64'd10)
         overflowed = 1;
      else
         magnitude = magnitude * 64'd10 + d;
   endfunction

   function automatic void scan_char(logic [7:0] c);
      case (scan_phase)
         SCAN_KEY: begin
            if (c == kvdp_pkg::CHAR_EQUALS) begin
               if (key_count == 0)
                  scan_phase = SCAN_KEY_EMPTY;
               else if (key_count >= KEY_CAPACITY)
                  scan_phase = SCAN_KEY_LONG;
               else
                  scan_phase = SCAN_SPACE;
            end else begin
               if (key_count < KEY_CAPACITY - 1)
                  key_bytes[key_count] = c;
               if (key_count < KEY_CAPACITY)
                  key_count++;
            end
         end
         SCAN_SPACE: begin
            if (is_space_char(c)) begin
            end else if (c == kvdp_pkg::CHAR_PLUS || c == kvdp_pkg::CHAR_MINUS) begin
               negative   = (c == kvdp_pkg::CHAR_MINUS);
               scan_phase = SCAN_SIGN;
            end else if (is_digit_char(c)) begin
               accumulate_digit(c);
               scan_phase = SCAN_DIGITS;
            end else begin
               scan_phase = SCAN_NODIGIT;
            end
         end
         SCAN_SIGN: begin
            if (is_digit_char(c)) begin
               accumulate_digit(c);
               scan_phase = SCAN_DIGITS;
            end else begin
               scan_phase = SCAN_NODIGIT;
            end
         end
         SCAN_DIGITS: begin
            if (is_digit_char(c))
               accumulate_digit(c);
            else
               scan_phase = SCAN_JUNK;
         end
         default: begin
         end
      endcase
      if (line_pos < OFFSET_MAX)
         line_pos++;
   endfunction

   function automatic void close_line();
      parse_result_type item;
      logic [1:0]       code;
      logic [15:0]      off;
      logic [15:0]      val_off;
      logic [63:0]      val;
      code    = kvdp_pkg::STATUS_OK;
      off     = '0;
      val     = '0;
      val_off = (key_count + 1 > OFFSET_MAX) ? 16'(OFFSET_MAX) : 16'(key_count + 1);
      case (scan_phase)
         SCAN_KEY: begin
            code = kvdp_pkg::STATUS_JUNK;
            off  = 16'(line_pos);
         end
         SCAN_KEY_EMPTY: code = kvdp_pkg::STATUS_EMPTY;
         SCAN_KEY_LONG:  code = kvdp_pkg::STATUS_RANGE;
         SCAN_SPACE, SCAN_SIGN, SCAN_NODIGIT: begin
            code = kvdp_pkg::STATUS_EMPTY;
            off  = val_off;
         end
         SCAN_JUNK: begin
            code = kvdp_pkg::STATUS_JUNK;
            off  = val_off;
         end
         default: begin
            if (overflowed) begin
               code = kvdp_pkg::STATUS_RANGE;
               off  = val_off;
            end else begin
               val = negative ? -magnitude : magnitude;
            end
         end
      endcase
      if (code == kvdp_pkg::STATUS_OK) begin
         for (int i = 0; i < key_count && i < KEY_CAPACITY - 1; i++) begin
            item.is_status     = 1'b0;
            item.key_char      = key_bytes[i];
            item.status.code   = kvdp_pkg::STATUS_OK;
            item.status.offset = '0;
            item.status.value  = '0;
            line_results.push_back(item);
         end
      end
      item.is_status     = 1'b1;
      item.key_char      = '0;
      item.status.code   = code;
      item.status.offset = off;
      item.status.value  = val;
      line_results.push_back(item);
      clear_scan();
   endfunction

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // response side: check at each handshake, then pick the next ready value
   initial begin
      logic [15:0]      pattern;
      int               pat_pos;
      parse_result_type want;
      pattern = '1;
      pat_pos = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (line_results.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = line_results.pop_front();
               check_field("is_status", 64'(want.is_status), 64'(rsp_if.is_status));
               check_field("key_char", 64'(want.key_char), 64'(rsp_if.key_char));
               check_field("status_code", 64'(want.status.code),
                           64'(rsp_if.status_code));
               check_field("error_offset", 64'(want.status.offset),
                           64'(rsp_if.error_offset));
               check_field("parsed_value", want.status.value, rsp_if.parsed_value);
            end
         end
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else if (!rsp_stall_on) begin
            rsp_if.ready <= 1'b1;
         end else begin
            if (pat_pos == 0)
               pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            rsp_if.ready <= pattern[pat_pos];
            pat_pos = (pat_pos + 1) % 16;
         end
      end
   end

   task automatic send_item(input logic [7:0] c, input logic e);
      if (!sender_active) begin
         req_if.valid <= 1'b1;
         sender_active = 1;
      end
      req_if.char_code <= c;
      req_if.line_end  <= e;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      items_sent++;
      if (e || c == kvdp_pkg::CHAR_NUL)
         close_line();
      else
         scan_char(c);
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            sender_active = 0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            burst_left = $urandom_range(0, 20);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   // either end marker form; the byte beside line_end is don't-care
   task automatic send_end();
      if ($urandom_range(0, 2) == 0)
         send_item(kvdp_pkg::CHAR_NUL, 1'b0);
      else
         send_item(8'($urandom), 1'b1);
   endtask

   task automatic send_line(input string s);
      send_text(s);
      send_end();
   endtask

   task automatic send_key(input int n);
      logic [7:0] c;
      repeat (n) begin
         do
            c = 8'($urandom_range(1, 255));
         while (c == kvdp_pkg::CHAR_EQUALS);
         send_item(c, 1'b0);
      end
   endtask

   task automatic send_space();
      int pick;
      pick = $urandom_range(8, 13);
      send_item((pick == 8) ? kvdp_pkg::CHAR_SPACE : 8'(pick), 1'b0);
   endtask

   task automatic send_digits();
      case ($urandom_range(0, 3))
         0, 1: repeat ($urandom_range(1, 6))
                  send_item(kvdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         2:    repeat ($urandom_range(18, 21))
                  send_item(kvdp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
         default: begin
            repeat ($urandom_range(0, 2)) send_item(kvdp_pkg::CHAR_ZERO, 1'b0);
            case ($urandom_range(0, 3))
               0: send_text("9223372036854775807");
               1: send_text("9223372036854775808");
               2: send_text("9223372036854775809");
               default: send_text("0");
            endcase
         end
      endcase
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      if (sender_active) begin
         req_if.valid <= 1'b0;
         sender_active = 0;
      end
      while (line_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (line_results.size() != 0) begin
         $error("%0d responses never arrived", line_results.size());
         error_count++;
         line_results.delete();
      end
      repeat (KEY_CAPACITY + 8) @(posedge clock);
   endtask

   task automatic test_value_edges();
      gaps_on = 1;
      rsp_stall_on = 1;
      send_line("count=42");
      send_line("k=9223372036854775807");
      send_line("k=-9223372036854775808");
      send_line("k=9223372036854775808");
      send_line("k=-9223372036854775809");
      send_line("k=\011\012\013\014\015 +007");
      send_line("k=-0");
      wait_drained();
   endtask

   task automatic test_malformed_values();
      send_line("ab=");
      send_line("k=+");
      send_line("k= -x");
      send_line("k=12 ");
      send_line("k=1=2");
      send_line("k==3");
      // junk after digits wins over overflow
      send_line("k=99999999999999999999x");
      send_line("novalue");
      send_end();
      wait_drained();
   endtask

   task automatic test_key_lengths();
      send_line("=17");
      send_line("==");
      send_line("x=1");
      send_item(8'hFF, 1'b0);
      send_item(8'h01, 1'b0);
      send_key(KEY_CAPACITY - 3);
      send_line("=5");
      send_key(KEY_CAPACITY);
      send_line("=5");
      wait_drained();
   endtask

   task automatic test_backpressure();
      gaps_on = 0;
      rsp_stall_on = 0;
      hold_cycles = 400;
      repeat (2) begin
         send_key($urandom_range(1, 8));
         send_item(kvdp_pkg::CHAR_EQUALS, 1'b0);
         send_digits();
         send_end();
      end
      wait_drained();
   endtask

   task automatic send_random_line();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         send_key(($urandom_range(0, 3) == 0) ? $urandom_range(9, KEY_CAPACITY - 1)
                                              : $urandom_range(1, 8));
         send_item(kvdp_pkg::CHAR_EQUALS, 1'b0);
         repeat ($urandom_range(0, 2)) send_space();
         case ($urandom_range(0, 2))
            1: send_item(kvdp_pkg::CHAR_PLUS, 1'b0);
            2: send_item(kvdp_pkg::CHAR_MINUS, 1'b0);
            default: begin
            end
         endcase
         send_digits();
         if ($urandom_range(0, 5) == 0)
            send_item(8'($urandom_range(1, 255)), 1'b0);
      end else if (kind == 7) begin
         repeat ($urandom_range(0, 12)) send_item(8'($urandom_range(1, 255)), 1'b0);
      end else if (kind == 8) begin
         send_key(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(KEY_CAPACITY,
                                                                  KEY_CAPACITY + 2));
         send_item(kvdp_pkg::CHAR_EQUALS, 1'b0);
         send_digits();
      end else begin
         send_key($urandom_range(1, 4));
         send_item(kvdp_pkg::CHAR_EQUALS, 1'b0);
         case ($urandom_range(0, 3))
            0: begin
            end
            1: send_item(($urandom_range(0, 1) == 0) ? kvdp_pkg::CHAR_PLUS
                                                     : kvdp_pkg::CHAR_MINUS, 1'b0);
            2: send_item(kvdp_pkg::CHAR_EQUALS, 1'b0);
            default: begin
               send_space();
               send_item(8'($urandom_range(1, 255)), 1'b0);
            end
         endcase
      end
      send_end();
   endtask

   task automatic test_random_lines();
      int first;
      first = items_sent;
      gaps_on = 1;
      rsp_stall_on = 1;
      while (items_sent - first < RANDOM_ITEMS)
         send_random_line();
      wait_drained();
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = '0;
      req_if.line_end  = 1'b0;
      error_count   = 0;
      items_sent    = 0;
      burst_left    = 0;
      hold_cycles   = 0;
      gaps_on       = 0;
      rsp_stall_on  = 0;
      sender_active = 0;
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_value_edges();
      test_malformed_values();
      test_key_lengths();
      test_backpressure();
      test_random_lines();

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
